>>> hw/rtl/cprgb_pkg.sv
// Shared types and codes for the camera pixel to RGB converter.
`timescale 1ns / 1ps

package cprgb_pkg;

    // pixel_format codes
    localparam logic [2:0] FMT_RGB  = 3'd0;
    localparam logic [2:0] FMT_BGR  = 3'd1;
    localparam logic [2:0] FMT_YUYV = 3'd2;
    localparam logic [2:0] FMT_UYVY = 3'd3;
    localparam logic [2:0] FMT_NV12 = 3'd4;
    localparam logic [2:0] FMT_NV21 = 3'd5;

    // register index of pixel_format
    localparam logic REG_PIXEL_FORMAT = 1'b0;

    // what the output stage builds from a beat
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_PASS = 2'd1;
    localparam logic [1:0] KIND_YUV  = 2'd2;

    typedef struct packed {
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
    } yuv_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        rgb_t       pass;
    } ctrl_t;

endpackage

>>> hw/rtl/cprgb_lane.sv
// One BT.601 limited-range YUV to RGB lane, two register stages.
`timescale 1ns / 1ps

module cprgb_lane (
    input  logic            clk,
    input  cprgb_pkg::yuv_t pix,
    output cprgb_pkg::rgb_t rgb
);
    import cprgb_pkg::*;

    logic signed [9:0]  c;
    logic signed [8:0]  d;
    logic signed [8:0]  e;

    logic signed [17:0] yc_reg, yc_next;
    logic signed [16:0] re_reg, re_next;
    logic signed [14:0] gd_reg, gd_next;
    logic signed [15:0] ge_reg, ge_next;
    logic signed [17:0] bd_reg, bd_next;

    logic signed [19:0] r_sum, g_sum, b_sum;
    rgb_t               rgb_reg, rgb_next;

    // floor(sum / 256) clamped to 0..255
    function automatic logic [7:0] sat8(input logic signed [19:0] s);
        logic [7:0] q;
        if (s[19])
            q = 8'd0;
        else if (s[18:16] != 3'd0)
            q = 8'd255;
        else
            q = s[15:8];
        return q;
    endfunction

    assign c = $signed({2'b00, pix.y}) - 10'sd16;
    assign d = $signed({1'b0, pix.u}) - 9'sd128;
    assign e = $signed({1'b0, pix.v}) - 9'sd128;

    // stage 1: constant products
    assign yc_next = 18'(c) * 18'sd298;
    assign re_next = 17'(e) * 17'sd409;
    assign gd_next = 15'(d) * 15'sd100;
    assign ge_next = 16'(e) * 16'sd208;
    assign bd_next = 18'(d) * 18'sd516;

    // stage 2: sum, round, clamp
    assign r_sum = 20'(yc_reg) + 20'(re_reg) + 20'sd128;
    assign g_sum = 20'(yc_reg) - 20'(gd_reg) - 20'(ge_reg) + 20'sd128;
    assign b_sum = 20'(yc_reg) + 20'(bd_reg) + 20'sd128;

    always_comb
    begin
        rgb_next.r = sat8(r_sum);
        rgb_next.g = sat8(g_sum);
        rgb_next.b = sat8(b_sum);
    end

    always_ff @(posedge clk)
    begin
        yc_reg  <= yc_next;
        re_reg  <= re_next;
        gd_reg  <= gd_next;
        ge_reg  <= ge_next;
        bd_reg  <= bd_next;
        rgb_reg <= rgb_next;
    end

    assign rgb = rgb_reg;

endmodule

>>> hw/rtl/cprgb_merge.sv
// Output stage: merges lane results or passthrough bytes into one result beat.
`timescale 1ns / 1ps

module cprgb_merge (
    input  logic             clk,
    input  logic             rst_n,
    input  cprgb_pkg::ctrl_t ctrl,
    input  cprgb_pkg::rgb_t  lane0,
    input  cprgb_pkg::rgb_t  lane1,
    output logic             done,
    output cprgb_pkg::rgb_t  pix0,
    output cprgb_pkg::rgb_t  pix1,
    output logic [1:0]       count
);
    import cprgb_pkg::*;

    logic       done_reg, done_next;
    rgb_t       pix0_reg, pix0_next;
    rgb_t       pix1_reg, pix1_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        done_next = ctrl.valid;
        case (ctrl.kind)
            KIND_PASS:
            begin
                pix0_next  = ctrl.pass;
                pix1_next  = '0;
                count_next = 2'd1;
            end
            KIND_YUV:
            begin
                pix0_next  = lane0;
                pix1_next  = lane1;
                count_next = 2'd2;
            end
            default:
            begin
                pix0_next  = '0;
                pix1_next  = '0;
                count_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        pix0_reg  <= pix0_next;
        pix1_reg  <= pix1_next;
        count_reg <= count_next;
    end

    assign done  = done_reg;
    assign pix0  = pix0_reg;
    assign pix1  = pix1_reg;
    assign count = count_reg;

endmodule

>>> hw/rtl/camera_pixel_to_rgb_converter.sv
// Top level: camera pixel group to packed RGB888 converter.
// A beat taken with start passes the unpack, product, sum/clamp and output registers
// in that order before it shows on the result ports with done high.
// Throughput: one beat per clock; busy is never raised, results cannot be held off.
// Reset: rst_n (async, active low) clears the pipeline valids and sets pixel_format
// to RGB; no clearing pass is needed.
`timescale 1ns / 1ps

module camera_pixel_to_rgb_converter (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // command side
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  in_byte0,
    input  logic [7:0]  in_byte1,
    input  logic [7:0]  in_byte2,
    input  logic [7:0]  in_byte3,
    // result side
    output logic        done,
    output logic [7:0]  red0,
    output logic [7:0]  green0,
    output logic [7:0]  blue0,
    output logic [7:0]  red1,
    output logic [7:0]  green1,
    output logic [7:0]  blue1,
    output logic [1:0]  pixel_count
);
    import cprgb_pkg::*;

    logic [2:0] fmt_reg, fmt_next;
    logic       cfg_wr;
    logic       accept;

    // stage A: unpacked beat
    ctrl_t ctrl_a_reg, ctrl_a_next;
    yuv_t  yuv0_reg, yuv0_next;
    yuv_t  yuv1_reg, yuv1_next;

    // control delayed to line up with the two lane stages
    ctrl_t ctrl_b_reg;
    ctrl_t ctrl_c_reg;

    rgb_t  lane0_rgb;
    rgb_t  lane1_rgb;
    rgb_t  out0;
    rgb_t  out1;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        fmt_next = fmt_reg;
        if (cfg_wr && (paddr[2] == REG_PIXEL_FORMAT))
            fmt_next = pwdata[2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= FMT_RGB;
        else
            fmt_reg <= fmt_next;
    end

    assign prdata = (paddr[2] == REG_PIXEL_FORMAT) ? {29'd0, fmt_reg} : 32'd0;

    // ---------------- input and unpack ----------------
    // Pipeline never stalls, so a beat is taken whenever start is high.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        ctrl_a_next.valid = accept;
        ctrl_a_next.kind  = KIND_YUV;
        ctrl_a_next.pass  = '{r: in_byte0, g: in_byte1, b: in_byte2};
        yuv0_next         = '{y: in_byte0, u: in_byte1, v: in_byte3};
        yuv1_next         = '{y: in_byte2, u: in_byte1, v: in_byte3};
        case (fmt_reg)
            FMT_RGB:
                ctrl_a_next.kind = KIND_PASS;
            FMT_BGR:
            begin
                ctrl_a_next.kind = KIND_PASS;
                ctrl_a_next.pass = '{r: in_byte2, g: in_byte1, b: in_byte0};
            end
            FMT_YUYV:
            begin
                // Y0 U Y1 V
                yuv0_next = '{y: in_byte0, u: in_byte1, v: in_byte3};
                yuv1_next = '{y: in_byte2, u: in_byte1, v: in_byte3};
            end
            FMT_UYVY:
            begin
                // U Y0 V Y1
                yuv0_next = '{y: in_byte1, u: in_byte0, v: in_byte2};
                yuv1_next = '{y: in_byte3, u: in_byte0, v: in_byte2};
            end
            FMT_NV12:
            begin
                // Y0 Y1 U V
                yuv0_next = '{y: in_byte0, u: in_byte2, v: in_byte3};
                yuv1_next = '{y: in_byte1, u: in_byte2, v: in_byte3};
            end
            FMT_NV21:
            begin
                // Y0 Y1 V U
                yuv0_next = '{y: in_byte0, u: in_byte3, v: in_byte2};
                yuv1_next = '{y: in_byte1, u: in_byte3, v: in_byte2};
            end
            default:
                // unknown format: a result with no valid pixel
                ctrl_a_next.kind = KIND_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_a_reg <= '0;
            ctrl_b_reg <= '0;
            ctrl_c_reg <= '0;
        end
        else
        begin
            ctrl_a_reg <= ctrl_a_next;
            ctrl_b_reg <= ctrl_a_reg;
            ctrl_c_reg <= ctrl_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        yuv0_reg <= yuv0_next;
        yuv1_reg <= yuv1_next;
    end

    // ---------------- two conversion lanes ----------------
    cprgb_lane u_lane0 (
        .clk (clk),
        .pix (yuv0_reg),
        .rgb (lane0_rgb)
    );

    cprgb_lane u_lane1 (
        .clk (clk),
        .pix (yuv1_reg),
        .rgb (lane1_rgb)
    );

    // ---------------- merge and output register ----------------
    cprgb_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl_c_reg),
        .lane0 (lane0_rgb),
        .lane1 (lane1_rgb),
        .done  (done),
        .pix0  (out0),
        .pix1  (out1),
        .count (pixel_count)
    );

    assign red0   = out0.r;
    assign green0 = out0.g;
    assign blue0  = out0.b;
    assign red1   = out1.r;
    assign green1 = out1.g;
    assign blue1  = out1.b;

endmodule
